[design/drd_pkg.sv]
// ----------------------------------------------------------------------------
// drd_pkg: detection row decode shared definitions
// Register indexes, row element positions and the stage payload structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package drd_pkg;

  // Configuration register indexes
  localparam logic [2:0] RegConfThreshold = 3'd0;
  localparam logic [2:0] RegNumClasses    = 3'd1;
  localparam logic [2:0] RegInvScale      = 3'd2;
  localparam logic [2:0] RegPadX          = 3'd3;
  localparam logic [2:0] RegPadY          = 3'd4;
  localparam logic [2:0] RegFrameWidth    = 3'd5;
  localparam logic [2:0] RegFrameHeight   = 3'd6;

  // Row layout: four box words, objectness, then the class scores
  localparam logic [7:0] ElemCx         = 8'd0;
  localparam logic [7:0] ElemCy         = 8'd1;
  localparam logic [7:0] ElemW          = 8'd2;
  localparam logic [7:0] ElemH          = 8'd3;
  localparam logic [7:0] ElemObj        = 8'd4;
  localparam logic [7:0] ElemFirstClass = 8'd5;

  // Class count limit; also the "no class" marker
  localparam logic [7:0] MaxClasses = 8'd128;

  // Half of one output pixel in Q21 units
  localparam logic [20:0] RoundHalf = 21'h10_0000;

  // Finished row, captured at its last word
  typedef struct packed {
    logic [17:0] cx;
    logic [17:0] cy;
    logic [17:0] bw;
    logic [17:0] bh;
    logic [17:0] obj;
    logic [17:0] best;
    logic [7:0]  cls;
  } drd_row_t;

  // Products of the scaling stage
  typedef struct packed {
    logic [17:0]        obj;
    logic [35:0]        conf_prod;
    logic signed [36:0] left;
    logic signed [36:0] top;
    logic [34:0]        size_w;
    logic [34:0]        size_h;
    logic [7:0]         cls;
  } drd_prod_t;

endpackage

`default_nettype wire

[design/drd_row_acc.sv]
// ----------------------------------------------------------------------------
// drd_row_acc: row accumulator
// Holds the box words and objectness, tracks the running class argmax and
// captures the finished row into a snapshot register at the row's last word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drd_row_acc
  import drd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic        advance_i,
  input  wire logic [17:0] value_i,
  input  wire logic [7:0]  num_classes_i,
  output logic             row_valid_o,
  output drd_row_t         row_o
);

  logic [7:0]  idx_q, idx_d;
  logic [17:0] cx_q, cy_q, bw_q, bh_q, obj_q;
  logic [17:0] best_q, best_d;
  logic [7:0]  cls_q, cls_d;
  logic [7:0]  nc_eff;
  logic        is_last;
  logic        row_valid_q;
  drd_row_t    row_q;

  // Class count clamped to 1..MaxClasses
  always_comb begin
    if (num_classes_i == 8'd0) begin
      nc_eff = 8'd1;
    end else if (num_classes_i > MaxClasses) begin
      nc_eff = MaxClasses;
    end else begin
      nc_eff = num_classes_i;
    end
  end

  assign is_last = {1'b0, idx_q} >= (9'd4 + {1'b0, nc_eff});

  // Running strictly-greater argmax
  always_comb begin
    best_d = best_q;
    cls_d  = cls_q;
    if (idx_q >= ElemFirstClass && value_i > best_q) begin
      best_d = value_i;
      cls_d  = idx_q - ElemFirstClass;
    end
  end

  assign idx_d = is_last ? 8'd0 : idx_q + 8'd1;

  // Row state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 8'd0;
      best_q <= 18'd0;
      cls_q  <= MaxClasses;
      cx_q   <= 18'd0;
      cy_q   <= 18'd0;
      bw_q   <= 18'd0;
      bh_q   <= 18'd0;
      obj_q  <= 18'd0;
    end else if (accept_i) begin
      idx_q <= idx_d;
      case (idx_q)
        ElemCx:  cx_q  <= value_i;
        ElemCy:  cy_q  <= value_i;
        ElemW:   bw_q  <= value_i;
        ElemH:   bh_q  <= value_i;
        ElemObj: obj_q <= value_i;
        default: ;
      endcase
      if (is_last) begin
        best_q <= 18'd0;
        cls_q  <= MaxClasses;
      end else begin
        best_q <= best_d;
        cls_q  <= cls_d;
      end
    end
  end

  // Snapshot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= 1'b0;
    end else if (advance_i) begin
      row_valid_q <= accept_i && is_last;
    end
  end

  // Snapshot payload; the last word is never a box word
  always_ff @(posedge clk_i) begin
    if (accept_i && is_last) begin
      row_q.cx   <= cx_q;
      row_q.cy   <= cy_q;
      row_q.bw   <= bw_q;
      row_q.bh   <= bh_q;
      row_q.obj  <= obj_q;
      row_q.best <= best_d;
      row_q.cls  <= cls_d;
    end
  end

  assign row_valid_o = row_valid_q;
  assign row_o       = row_q;

  // Element index never runs past the end of the longest row
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, idx_q} <= (9'd4 + {1'b0, MaxClasses}))
    else $error("element index past row end");

endmodule

`default_nettype wire

[design/drd_scale.sv]
// ----------------------------------------------------------------------------
// drd_scale: confidence and letterbox products
// Forms objectness*score and the box edges and sizes times the reciprocal
// scale, all exact, into one register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drd_scale
  import drd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        advance_i,
  input  wire logic        row_valid_i,
  input  drd_row_t         row_i,
  input  wire logic [15:0] inv_scale_i,
  input  wire logic [9:0]  pad_x_i,
  input  wire logic [9:0]  pad_y_i,
  output logic             prod_valid_o,
  output drd_prod_t        prod_o
);

  logic signed [20:0] left_diff, top_diff;
  logic signed [16:0] inv_s;
  drd_prod_t          prod_d, prod_q;
  logic               prod_valid_q;

  // Edges in half model pixels: 2*center - size - 2*pad (Q10.9)
  assign left_diff = $signed({2'b00, row_i.cx, 1'b0}) - $signed({3'b000, row_i.bw})
                   - $signed({2'b00, pad_x_i, 9'd0});
  assign top_diff  = $signed({2'b00, row_i.cy, 1'b0}) - $signed({3'b000, row_i.bh})
                   - $signed({2'b00, pad_y_i, 9'd0});
  assign inv_s     = $signed({1'b0, inv_scale_i});

  always_comb begin
    prod_d.obj       = row_i.obj;
    prod_d.conf_prod = row_i.obj * row_i.best;
    prod_d.left      = left_diff * inv_s;
    prod_d.top       = top_diff * inv_s;
    prod_d.size_w    = {row_i.bw, 1'b0} * inv_scale_i;
    prod_d.size_h    = {row_i.bh, 1'b0} * inv_scale_i;
    prod_d.cls       = row_i.cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (advance_i) begin
      prod_valid_q <= row_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && row_valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = prod_valid_q;
  assign prod_o       = prod_q;

endmodule

`default_nettype wire

[design/drd_finish.sv]
// ----------------------------------------------------------------------------
// drd_finish: rounding, clamping, thresholds and result register
// Rounds the scaled box to pixels, clamps it to the frame, applies both
// confidence thresholds and holds the result word for the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drd_finish
  import drd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        advance_i,
  input  wire logic        prod_valid_i,
  input  drd_prod_t        prod_i,
  input  wire logic [8:0]  conf_threshold_i,
  input  wire logic [11:0] frame_width_i,
  input  wire logic [11:0] frame_height_i,
  output logic             out_valid_o,
  output logic             kept_o,
  output logic [7:0]       class_id_o,
  output logic [8:0]       confidence_o,
  output logic [11:0]      box_x_o,
  output logic [11:0]      box_y_o,
  output logic [11:0]      box_w_o,
  output logic [11:0]      box_h_o
);

  logic [36:0]        left_sum, top_sum;
  logic [35:0]        w_sum, h_sum;
  logic [15:0]        x_px, y_px;
  logic [14:0]        w_px, h_px;
  logic signed [17:0] lim_w, lim_h;
  logic [14:0]        w_clip, h_clip;
  logic [8:0]         conf;
  logic               thr_ok, size_ok, kept;

  logic               out_valid_q;
  logic               kept_q;
  logic [7:0]         cls_q;
  logic [8:0]         conf_q;
  logic [11:0]        x_q, y_q, w_q, h_q;

  // Round half away from zero; negative edges clamp to zero anyway
  assign left_sum = {1'b0, prod_i.left[35:0]} + {16'd0, RoundHalf};
  assign top_sum  = {1'b0, prod_i.top[35:0]} + {16'd0, RoundHalf};
  assign w_sum    = {1'b0, prod_i.size_w} + {15'd0, RoundHalf};
  assign h_sum    = {1'b0, prod_i.size_h} + {15'd0, RoundHalf};

  assign x_px = prod_i.left[36] ? 16'd0 : left_sum[36:21];
  assign y_px = prod_i.top[36] ? 16'd0 : top_sum[36:21];
  assign w_px = w_sum[35:21];
  assign h_px = h_sum[35:21];

  // Room left in the frame past the left/top edge
  assign lim_w = $signed({6'd0, frame_width_i}) - $signed({2'b00, x_px});
  assign lim_h = $signed({6'd0, frame_height_i}) - $signed({2'b00, y_px});

  assign w_clip = ($signed({3'b000, w_px}) < lim_w) ? w_px : lim_w[14:0];
  assign h_clip = ($signed({3'b000, h_px}) < lim_h) ? h_px : lim_h[14:0];

  assign size_ok = (w_px != 15'd0) && (lim_w > 18'sd0)
                && (h_px != 15'd0) && (lim_h > 18'sd0);

  // Confidence, saturated to 1.0
  assign conf = (prod_i.conf_prod[35:8] > 28'd256) ? 9'd256 : prod_i.conf_prod[16:8];

  assign thr_ok = (prod_i.obj >= {9'd0, conf_threshold_i})
               && (prod_i.conf_prod >= {19'd0, conf_threshold_i, 8'd0});

  assign kept = thr_ok && size_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_i) begin
      out_valid_q <= prod_valid_i;
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (advance_i && prod_valid_i) begin
      kept_q <= kept;
      cls_q  <= prod_i.cls;
      conf_q <= conf;
      x_q    <= kept ? x_px[11:0] : 12'd0;
      y_q    <= kept ? y_px[11:0] : 12'd0;
      w_q    <= kept ? w_clip[11:0] : 12'd0;
      h_q    <= kept ? h_clip[11:0] : 12'd0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kept_o       = kept_q;
  assign class_id_o   = cls_q;
  assign confidence_o = conf_q;
  assign box_x_o      = x_q;
  assign box_y_o      = y_q;
  assign box_w_o      = w_q;
  assign box_h_o      = h_q;

  // A kept detection always has a nonzero size
  a_kept_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kept_q |-> (w_q != 12'd0) && (h_q != 12'd0))
    else $error("kept detection with empty box");

  // A dropped detection carries an all-zero box
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !kept_q |-> (x_q == 12'd0) && (y_q == 12'd0)
                            && (w_q == 12'd0) && (h_q == 12'd0))
    else $error("dropped detection with nonzero box");

endmodule

`default_nettype wire

[design/detection_row_decode_core.sv]
// ----------------------------------------------------------------------------
// detection_row_decode_core: detector output row decoder
// Streams one prediction row in, word by word, and returns one decoded,
// thresholded and frame-clamped detection word per row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/value_i) takes one Q10.8 word per
//   cycle: center x, center y, width, height, objectness, then num_classes
//   class scores; a row is 5 + num_classes words (count clamped to 1..128).
//   Output channel (out_valid_o/out_ready_i) gives one result word per row.
//   Configuration writes (cfg_we_i/cfg_addr_i/cfg_wdata_i) take effect at
//   once and belong between rows while the pipeline is empty.
//   Result path: once the row's last word is accepted, the result passes the
//   snapshot register, product register and result register in that order.
//   Throughput: one input word per cycle, sustained; rows end at most every
//   six words and the three-stage pipeline drains one row per cycle.
//   When the receiver stalls, the result is held and the stages behind it
//   keep filling; in_ready_o drops only while all three stages are full.
//   Reset: empty pipeline, row index at the first word, registers at their
//   defaults (threshold 64, 5 classes, unit scale, no pad, 640x480 frame).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module detection_row_decode_core
  import drd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [17:0] value_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kept_o,
  output logic [7:0]       class_id_o,
  output logic [8:0]       confidence_o,
  output logic [11:0]      box_x_o,
  output logic [11:0]      box_y_o,
  output logic [11:0]      box_w_o,
  output logic [11:0]      box_h_o
);

  logic [8:0]  conf_threshold_q;
  logic [7:0]  num_classes_q;
  logic [15:0] inv_scale_q;
  logic [9:0]  pad_x_q, pad_y_q;
  logic [11:0] frame_width_q, frame_height_q;

  logic        accept;
  logic        row_valid, prod_valid;
  logic        adv_row, adv_prod, adv_out;
  drd_row_t    row;
  drd_prod_t   prod;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_threshold_q <= 9'd64;
      num_classes_q    <= 8'd5;
      inv_scale_q      <= 16'd4096;
      pad_x_q          <= 10'd0;
      pad_y_q          <= 10'd0;
      frame_width_q    <= 12'd640;
      frame_height_q   <= 12'd480;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegConfThreshold: conf_threshold_q <= cfg_wdata_i[8:0];
        RegNumClasses:    num_classes_q    <= cfg_wdata_i[7:0];
        RegInvScale:      inv_scale_q      <= cfg_wdata_i;
        RegPadX:          pad_x_q          <= cfg_wdata_i[9:0];
        RegPadY:          pad_y_q          <= cfg_wdata_i[9:0];
        RegFrameWidth:    frame_width_q    <= cfg_wdata_i[11:0];
        RegFrameHeight:   frame_height_q   <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // Stage advance chain: a stage moves when the one ahead of it frees up
  assign adv_out    = !out_valid_o || out_ready_i;
  assign adv_prod   = !prod_valid || adv_out;
  assign adv_row    = !row_valid || adv_prod;
  assign in_ready_o = adv_row;
  assign accept     = in_valid_i && in_ready_o;

  drd_row_acc u_row_acc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .advance_i     (adv_row),
    .value_i       (value_i),
    .num_classes_i (num_classes_q),
    .row_valid_o   (row_valid),
    .row_o         (row)
  );

  drd_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (adv_prod),
    .row_valid_i  (row_valid),
    .row_i        (row),
    .inv_scale_i  (inv_scale_q),
    .pad_x_i      (pad_x_q),
    .pad_y_i      (pad_y_q),
    .prod_valid_o (prod_valid),
    .prod_o       (prod)
  );

  drd_finish u_finish (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (adv_out),
    .prod_valid_i     (prod_valid),
    .prod_i           (prod),
    .conf_threshold_i (conf_threshold_q),
    .frame_width_i    (frame_width_q),
    .frame_height_i   (frame_height_q),
    .out_valid_o      (out_valid_o),
    .kept_o           (kept_o),
    .class_id_o       (class_id_o),
    .confidence_o     (confidence_o),
    .box_x_o          (box_x_o),
    .box_y_o          (box_y_o),
    .box_w_o          (box_w_o),
    .box_h_o          (box_h_o)
  );

  // Input stalls only with every stage full and the result not taken
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && prod_valid && row_valid && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // A held result with a full pipeline stays valid and is not lost
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && prod_valid && row_valid |=> out_valid_o)
    else $error("result lost while stalled");

endmodule

`default_nettype wire
